FILE: design/g2l_pkg.sv
// Package with the year table, cumulative day counts and shared types for the date converter.
package g2l_pkg;

    localparam int FIRST_YEAR_DEF  = 1901;
    localparam int TABLE_YEARS_DEF = 199;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WORD_W  = 24;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_WALK = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    function automatic logic [WORD_W-1:0] year_word(input logic [7:0] idx);
        logic [WORD_W-1:0] r;
        begin
            case (idx)
                8'd0: r = 24'h04AE53; 8'd1: r = 24'h0A5748; 8'd2: r = 24'h5526BD;
                8'd3: r = 24'h0D2650; 8'd4: r = 24'h0D9544; 8'd5: r = 24'h46AAB9;
                8'd6: r = 24'h056A4D; 8'd7: r = 24'h09AD42; 8'd8: r = 24'h24AEB6;
                8'd9: r = 24'h04AE4A; 8'd10: r = 24'h6A4DBE; 8'd11: r = 24'h0A4D52;
                8'd12: r = 24'h0D2546; 8'd13: r = 24'h5D52BA; 8'd14: r = 24'h0B544E;
                8'd15: r = 24'h0D6A43; 8'd16: r = 24'h296D37; 8'd17: r = 24'h095B4B;
                8'd18: r = 24'h749BC1; 8'd19: r = 24'h049754; 8'd20: r = 24'h0A4B48;
                8'd21: r = 24'h5B25BC; 8'd22: r = 24'h06A550; 8'd23: r = 24'h06D445;
                8'd24: r = 24'h4ADAB8; 8'd25: r = 24'h02B64D; 8'd26: r = 24'h095742;
                8'd27: r = 24'h2497B7; 8'd28: r = 24'h04974A; 8'd29: r = 24'h664B3E;
                8'd30: r = 24'h0D4A51; 8'd31: r = 24'h0EA546; 8'd32: r = 24'h56D4BA;
                8'd33: r = 24'h05AD4E; 8'd34: r = 24'h02B644; 8'd35: r = 24'h393738;
                8'd36: r = 24'h092E4B; 8'd37: r = 24'h7C96BF; 8'd38: r = 24'h0C9553;
                8'd39: r = 24'h0D4A48; 8'd40: r = 24'h6DA53B; 8'd41: r = 24'h0B554F;
                8'd42: r = 24'h056A45; 8'd43: r = 24'h4AADB9; 8'd44: r = 24'h025D4D;
                8'd45: r = 24'h092D42; 8'd46: r = 24'h2C95B6; 8'd47: r = 24'h0A954A;
                8'd48: r = 24'h7B4ABD; 8'd49: r = 24'h06CA51; 8'd50: r = 24'h0B5546;
                8'd51: r = 24'h555ABB; 8'd52: r = 24'h04DA4E; 8'd53: r = 24'h0A5B43;
                8'd54: r = 24'h352BB8; 8'd55: r = 24'h052B4C; 8'd56: r = 24'h8A953F;
                8'd57: r = 24'h0E9552; 8'd58: r = 24'h06AA48; 8'd59: r = 24'h6AD53C;
                8'd60: r = 24'h0AB54F; 8'd61: r = 24'h04B645; 8'd62: r = 24'h4A5739;
                8'd63: r = 24'h0A574D; 8'd64: r = 24'h052642; 8'd65: r = 24'h3E9335;
                8'd66: r = 24'h0D9549; 8'd67: r = 24'h75AABE; 8'd68: r = 24'h056A51;
                8'd69: r = 24'h096D46; 8'd70: r = 24'h54AEBB; 8'd71: r = 24'h04AD4F;
                8'd72: r = 24'h0A4D43; 8'd73: r = 24'h4D26B7; 8'd74: r = 24'h0D254B;
                8'd75: r = 24'h8D52BF; 8'd76: r = 24'h0B5452; 8'd77: r = 24'h0B6A47;
                8'd78: r = 24'h696D3C; 8'd79: r = 24'h095B50; 8'd80: r = 24'h049B45;
                8'd81: r = 24'h4A4BB9; 8'd82: r = 24'h0A4B4D; 8'd83: r = 24'hAB25C2;
                8'd84: r = 24'h06A554; 8'd85: r = 24'h06D449; 8'd86: r = 24'h6ADA3D;
                8'd87: r = 24'h0AB651; 8'd88: r = 24'h093746; 8'd89: r = 24'h5497BB;
                8'd90: r = 24'h04974F; 8'd91: r = 24'h064B44; 8'd92: r = 24'h36A537;
                8'd93: r = 24'h0EA54A; 8'd94: r = 24'h86B2BF; 8'd95: r = 24'h05AC53;
                8'd96: r = 24'h0AB647; 8'd97: r = 24'h5936BC; 8'd98: r = 24'h092E50;
                8'd99: r = 24'h0C9645; 8'd100: r = 24'h4D4AB8; 8'd101: r = 24'h0D4A4C;
                8'd102: r = 24'h0DA541; 8'd103: r = 24'h25AAB6; 8'd104: r = 24'h056A49;
                8'd105: r = 24'h7AADBD; 8'd106: r = 24'h025D52; 8'd107: r = 24'h092D47;
                8'd108: r = 24'h5C95BA; 8'd109: r = 24'h0A954E; 8'd110: r = 24'h0B4A43;
                8'd111: r = 24'h4B5537; 8'd112: r = 24'h0AD54A; 8'd113: r = 24'h955ABF;
                8'd114: r = 24'h04BA53; 8'd115: r = 24'h0A5B48; 8'd116: r = 24'h652BBC;
                8'd117: r = 24'h052B50; 8'd118: r = 24'h0A9345; 8'd119: r = 24'h474AB9;
                8'd120: r = 24'h06AA4C; 8'd121: r = 24'h0AD541; 8'd122: r = 24'h24DAB6;
                8'd123: r = 24'h04B64A; 8'd124: r = 24'h69573D; 8'd125: r = 24'h0A4E51;
                8'd126: r = 24'h0D2646; 8'd127: r = 24'h5E933A; 8'd128: r = 24'h0D534D;
                8'd129: r = 24'h05AA43; 8'd130: r = 24'h36B537; 8'd131: r = 24'h096D4B;
                8'd132: r = 24'hB4AEBF; 8'd133: r = 24'h04AD53; 8'd134: r = 24'h0A4D48;
                8'd135: r = 24'h6D25BC; 8'd136: r = 24'h0D254F; 8'd137: r = 24'h0D5244;
                8'd138: r = 24'h5DAA38; 8'd139: r = 24'h0B5A4C; 8'd140: r = 24'h056D41;
                8'd141: r = 24'h24ADB6; 8'd142: r = 24'h049B4A; 8'd143: r = 24'h7A4BBE;
                8'd144: r = 24'h0A4B51; 8'd145: r = 24'h0AA546; 8'd146: r = 24'h5B52BA;
                8'd147: r = 24'h06D24E; 8'd148: r = 24'h0ADA42; 8'd149: r = 24'h355B37;
                8'd150: r = 24'h09374B; 8'd151: r = 24'h8497C1; 8'd152: r = 24'h049753;
                8'd153: r = 24'h064B48; 8'd154: r = 24'h66A53C; 8'd155: r = 24'h0EA54F;
                8'd156: r = 24'h06B244; 8'd157: r = 24'h4AB638; 8'd158: r = 24'h0AAE4C;
                8'd159: r = 24'h092E42; 8'd160: r = 24'h3C9735; 8'd161: r = 24'h0C9649;
                8'd162: r = 24'h7D4ABD; 8'd163: r = 24'h0D4A51; 8'd164: r = 24'h0DA545;
                8'd165: r = 24'h55AABA; 8'd166: r = 24'h056A4E; 8'd167: r = 24'h0A6D43;
                8'd168: r = 24'h452EB7; 8'd169: r = 24'h052D4B; 8'd170: r = 24'h8A95BF;
                8'd171: r = 24'h0A9553; 8'd172: r = 24'h0B4A47; 8'd173: r = 24'h6B553B;
                8'd174: r = 24'h0AD54F; 8'd175: r = 24'h055A45; 8'd176: r = 24'h4A5D38;
                8'd177: r = 24'h0A5B4C; 8'd178: r = 24'h052B42; 8'd179: r = 24'h3A93B6;
                8'd180: r = 24'h069349; 8'd181: r = 24'h7729BD; 8'd182: r = 24'h06AA51;
                8'd183: r = 24'h0AD546; 8'd184: r = 24'h54DABA; 8'd185: r = 24'h04B64E;
                8'd186: r = 24'h0A5743; 8'd187: r = 24'h452738; 8'd188: r = 24'h0D264A;
                8'd189: r = 24'h8E933E; 8'd190: r = 24'h0D5252; 8'd191: r = 24'h0DAA47;
                8'd192: r = 24'h66B53B; 8'd193: r = 24'h056D4F; 8'd194: r = 24'h04AE45;
                8'd195: r = 24'h4A4EB9; 8'd196: r = 24'h0A4D4C; 8'd197: r = 24'h0D1541;
                8'd198: r = 24'h2D92B5;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] r;
        begin
            case (m)
                4'd1: r = 9'd0;    4'd2: r = 9'd31;   4'd3: r = 9'd59;
                4'd4: r = 9'd90;   4'd5: r = 9'd120;  4'd6: r = 9'd151;
                4'd7: r = 9'd181;  4'd8: r = 9'd212;  4'd9: r = 9'd243;
                4'd10: r = 9'd273; 4'd11: r = 9'd304; 4'd12: r = 9'd334;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: design/g2l_if.sv
// Valid/ready channel interfaces for the date converter.
interface g2l_in_if;
    logic                          valid;
    logic                          ready;
    logic [g2l_pkg::YEAR_W-1:0]    solar_year;
    logic [g2l_pkg::MONTH_W-1:0]   solar_month;
    logic [g2l_pkg::DAY_W-1:0]     solar_day;
    modport source (output valid, solar_year, solar_month, solar_day, input ready);
    modport sink   (input valid, solar_year, solar_month, solar_day, output ready);
endinterface

interface g2l_out_if;
    logic                          valid;
    logic                          ready;
    logic [g2l_pkg::MONTH_W-1:0]   moon_month;
    logic [g2l_pkg::DAY_W-1:0]     moon_day;
    logic                          is_leap_month;
    logic                          out_of_range;
    modport source (output valid, moon_month, moon_day, is_leap_month, out_of_range,
                    input ready);
    modport sink   (input valid, moon_month, moon_day, is_leap_month, out_of_range,
                    output ready);
endinterface

FILE: design/gregorian_to_lunar_date.sv
// Top level of the Gregorian to lunar date converter.
// Usage: drive one beat on i_in (year, month, day); one result beat appears on o_out.
// The block takes a beat only in idle. It then reads the year word from the table,
// computes the day of year, and walks month by month through the year's slots with
// one shared add/compare unit, one slot per cycle, forward for dates on or after
// the lunar new year and backward through the previous year otherwise.
// A date out of range goes from the load state straight to the result, with no walk.
// The result is held in an output register until the receiver takes it; while
// o_out.ready is low the block holds the result and accepts no new beat.
// Synchronous reset returns the sequencer to idle with no result pending.
// The tables are constants, so reset leaves nothing to clear.
module gregorian_to_lunar_date #(
    parameter int FIRST_YEAR  = g2l_pkg::FIRST_YEAR_DEF,
    parameter int TABLE_YEARS = g2l_pkg::TABLE_YEARS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    g2l_in_if.sink        i_in,
    g2l_out_if.source     o_out
);
    localparam logic [12:0] FY = 13'(FIRST_YEAR);
    localparam logic [12:0] TY = 13'(TABLE_YEARS);

    g2l_pkg::t_state r_state, n_state;
    logic [23:0] r_word;      // word used by the walk
    logic [9:0]  r_rem;       // remaining days
    logic [3:0]  r_slot;
    logic        r_fwd;
    logic [3:0]  r_cnt;
    logic [3:0]  r_mon;
    logic [4:0]  r_day;
    logic        r_leap, r_oor;
    logic [11:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_dom;

    // Shared slot length lookup and subtract/compare.
    logic [4:0] w_len;
    logic [9:0] w_diff;
    logic       w_more;
    logic [3:0] w_lm;
    always_comb begin
        w_len  = r_word[5'd20 - {1'b0, r_slot}] ? 5'd30 : 5'd29;
        w_diff = r_rem - {5'd0, w_len};
        w_more = r_fwd ? (r_rem >= {5'd0, w_len}) : (r_rem > {5'd0, w_len});
        w_lm   = r_word[23:20];
    end

    // Year lookup and day of year.
    logic [12:0] w_yoff;
    logic [7:0]  w_idx;
    logic        w_bad;
    logic [23:0] w_cur, w_prev;
    logic [9:0]  w_doy, w_ny;
    always_comb begin
        w_yoff = {1'b0, r_year} - FY;
        w_bad  = ({1'b0, r_year} < FY) || (w_yoff >= TY) || (r_month < 4'd1)
               || (r_month > 4'd12) || (r_dom == 5'd0);
        w_idx  = w_yoff[7:0];
        w_cur  = g2l_pkg::year_word(w_idx);
        w_prev = g2l_pkg::year_word(w_idx - 8'd1);
        w_doy  = {1'b0, g2l_pkg::days_before(r_month)} + {5'd0, r_dom} - 10'd1
               + (((r_year[1:0] == 2'b00) && (r_month > 4'd2)) ? 10'd1 : 10'd0);
        w_ny   = {5'd0, w_cur[4:0]} - 10'd1 + ((w_cur[6:5] != 2'd1) ? 10'd31 : 10'd0);
    end

    // Month number and leap flag of the final slot.
    logic [3:0] w_mon;
    logic       w_leap;
    always_comb begin
        w_leap = 1'b0;
        w_mon  = r_slot;
        if (w_lm != 4'd0 && r_slot > w_lm) begin
            w_mon  = r_slot - 4'd1;
            w_leap = (r_slot == w_lm + 4'd1);
        end
    end

    logic w_stop;
    assign w_stop = r_fwd ? (r_slot >= r_cnt || !w_more) : (r_slot <= 4'd1 || !w_more);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            g2l_pkg::S_IDLE: if (i_in.valid) n_state = g2l_pkg::S_LOAD;
            g2l_pkg::S_LOAD: begin
                if (w_bad || (w_doy < w_ny && w_yoff == 13'd0)) n_state = g2l_pkg::S_DONE;
                else n_state = g2l_pkg::S_WALK;
            end
            g2l_pkg::S_WALK: if (w_stop) n_state = g2l_pkg::S_DONE;
            g2l_pkg::S_DONE: if (o_out.ready) n_state = g2l_pkg::S_IDLE;
            default: n_state = g2l_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= g2l_pkg::S_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            g2l_pkg::S_IDLE: begin
                r_year  <= i_in.solar_year;
                r_month <= i_in.solar_month;
                r_dom   <= i_in.solar_day;
            end
            g2l_pkg::S_LOAD: begin
                r_oor  <= 1'b1;
                r_mon  <= 4'd0;
                r_day  <= 5'd0;
                r_leap <= 1'b0;
                if (w_doy >= w_ny) begin
                    r_fwd  <= 1'b1;
                    r_word <= w_cur;
                    r_rem  <= w_doy - w_ny;
                    r_slot <= 4'd1;
                    r_cnt  <= (w_cur[23:20] != 4'd0) ? 4'd13 : 4'd12;
                end else begin
                    r_fwd  <= 1'b0;
                    r_word <= w_prev;
                    r_rem  <= w_ny - w_doy;
                    r_slot <= (w_prev[23:20] != 4'd0) ? 4'd13 : 4'd12;
                    r_cnt  <= 4'd1;
                end
            end
            g2l_pkg::S_WALK: begin
                if (w_stop) begin
                    r_oor  <= 1'b0;
                    r_mon  <= w_mon;
                    r_leap <= w_leap;
                    if (r_fwd)
                        r_day <= (r_rem >= 10'd31) ? 5'd31 : 5'(r_rem + 10'd1);
                    else
                        r_day <= (r_rem >= {5'd0, w_len}) ? 5'd1
                               : 5'({5'd0, w_len} - r_rem + 10'd1);
                end else begin
                    r_rem  <= w_diff;
                    r_slot <= r_fwd ? r_slot + 4'd1 : r_slot - 4'd1;
                end
            end
            g2l_pkg::S_DONE: ;
            default: ;
        endcase
    end

    assign i_in.ready          = (r_state == g2l_pkg::S_IDLE);
    assign o_out.valid         = (r_state == g2l_pkg::S_DONE);
    assign o_out.moon_month    = r_mon;
    assign o_out.moon_day      = r_day;
    assign o_out.is_leap_month = r_leap;
    assign o_out.out_of_range  = r_oor;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a result is pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> o_out.valid && $stable(o_out.moon_day))
        else $error("stalled result changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.out_of_range) |-> (o_out.moon_day != 5'd0))
        else $error("valid date with day zero");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == g2l_pkg::S_WALK) |-> (r_slot >= 4'd1 && r_slot <= 4'd13))
        else $error("slot index out of range");
endmodule
